// ===== design/ssg_pkg.sv =====
// Shared types, constants and GF(2) matrix functions of the stratified sample generator.
// No dependencies; imported by every module of the block.
package ssg_pkg;

   localparam int IDX_W         = 14;
   localparam int FRAC_W        = 23;
   localparam int JIT_W         = 16;
   localparam int WORD_W        = 32;
   localparam int HALF_W        = 16;
   localparam int FRAC_PAD_W    = FRAC_W - JIT_W;
   // Fraction scaler: split, reciprocal estimate, one-step correction.
   localparam int DIV_STAGES    = 3;
   localparam int CSR_IDX_W     = 2;

   localparam logic [FRAC_W-1:0] FRAC_MAX = '1;

   localparam logic [CSR_IDX_W-1:0] CSR_SCRAMBLE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCRAMBLE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SCRAMBLE_Z = 2'd2;

   typedef logic [WORD_W-1:0] word_type;
   typedef logic [WORD_W-1:0][WORD_W-1:0] matrix_type;

   typedef struct packed {
      word_type x;
      word_type y;
      word_type z;
   } scramble_type;

   typedef struct packed {
      logic valid;
      logic row_sat;
   } map_status_type;

   // Upper-triangular reverse matrix: output bit i is the parity of input bits 31-i and up.
   function automatic word_type rev_matrix(input word_type a);
      word_type acc;
      for (int i = 0; i < WORD_W; i++) begin
         acc[i] = ^(a >> (WORD_W - 1 - i));
      end
      return acc;
   endfunction

   // Inverse of the reverse matrix: bit-reverse, then xor with its own right shift.
   function automatic word_type inv_rev_matrix(input word_type a);
      word_type b;
      for (int i = 0; i < WORD_W; i++) begin
         b[i] = a[WORD_W - 1 - i];
      end
      return b ^ (b >> 1);
   endfunction

   // Rows of the third-dimension matrix, built at elaboration from its Pascal-like columns.
   function automatic matrix_type make_z_rows();
      matrix_type  rows;
      logic [63:0] col;
      word_type    c;
      rows = '0;
      col  = 64'h3 << 62;
      for (int k = 0; k < WORD_W; k++) begin
         c = col[62:31];
         for (int i = 0; i < WORD_W; i++) begin
            rows[i][k] = c[i];
         end
         col = col ^ (col >> 1);
      end
      return rows;
   endfunction

   localparam matrix_type Z_ROWS = make_z_rows();

   function automatic word_type z_matrix(input word_type seq);
      word_type acc;
      for (int i = 0; i < WORD_W; i++) begin
         acc[i] = ^(seq & Z_ROWS[i]);
      end
      return acc;
   endfunction

endpackage

// ===== design/ssg_map.sv =====
// Index split and GF(2) scrambling front end: input register, row/column split, matrices.
// Depends on ssg_pkg.
module ssg_map #(
   parameter int unsigned GRID_SIDE = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   input  logic [ssg_pkg::IDX_W-1:0]       in_index,
   input  ssg_pkg::scramble_type           scramble,
   output ssg_pkg::map_status_type         out_status,
   output logic [$clog2(GRID_SIDE)-1:0]    out_rem_x,
   output logic [$clog2(GRID_SIDE)-1:0]    out_rem_y,
   output logic [ssg_pkg::JIT_W-1:0]       out_jitter_x,
   output logic [ssg_pkg::JIT_W-1:0]       out_jitter_y,
   output logic [ssg_pkg::WORD_W-1:0]      out_z
);
   import ssg_pkg::*;

   localparam int GRID_W     = $clog2(GRID_SIDE);
   localparam int CELL_W     = (GRID_W < IDX_W) ? GRID_W : IDX_W;
   localparam int LOG_FLOOR  = $clog2(GRID_SIDE + 1) - 1;
   localparam int ROW_W      = (LOG_FLOOR < IDX_W) ? IDX_W - LOG_FLOOR : 1;
   localparam int PROD_SHIFT = IDX_W + GRID_W;
   localparam longint unsigned RECIP =
      ((64'd1 << PROD_SHIFT) + 64'(GRID_SIDE) - 64'd1) / 64'(GRID_SIDE);
   localparam int RECIP_W    = $clog2(RECIP + 1);
   localparam int PROD_W     = IDX_W + RECIP_W;

   logic                valid0_ff, valid1_ff;
   logic [IDX_W-1:0]    index0_ff, index1_ff;
   logic [ROW_W-1:0]    row_ff, row_in;
   logic [PROD_W-1:0]   prod;

   logic [IDX_W-1:0]    col_full;
   logic [CELL_W-1:0]   col;
   logic                row_sat;
   logic [HALF_W-1:0]   upper_half;
   word_type            upper, rev, delta, lower, seq;

   map_status_type      status_ff;
   logic [GRID_W-1:0]   rem_x_ff, rem_y_ff;
   logic [JIT_W-1:0]    jitter_x_ff, jitter_y_ff;
   word_type            z_ff;

   // Row = index / GRID_SIDE by reciprocal multiply, exact over the whole index range.
   assign prod   = PROD_W'(index0_ff) * PROD_W'(RECIP);
   assign row_in = ROW_W'(prod >> PROD_SHIFT);

   always_comb begin
      col_full   = index1_ff - IDX_W'(row_ff * GRID_SIDE);
      col        = CELL_W'(col_full);
      row_sat    = (32'(row_ff) >= GRID_SIDE);
      upper_half = HALF_W'(col) ^ scramble.x[WORD_W-1:HALF_W];
      upper      = {upper_half, HALF_W'(0)};
      rev        = rev_matrix(upper) ^ scramble.y;
      delta      = {HALF_W'(row_ff) ^ rev[WORD_W-1:HALF_W], HALF_W'(0)};
      lower      = inv_rev_matrix(delta);
      seq        = upper | lower;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff        <= 1'b0;
         valid1_ff        <= 1'b0;
         status_ff.valid  <= 1'b0;
      end else begin
         valid0_ff        <= in_valid;
         valid1_ff        <= valid0_ff;
         status_ff.valid  <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      index0_ff         <= in_index;
      index1_ff         <= index0_ff;
      row_ff            <= row_in;
      status_ff.row_sat <= row_sat;
      rem_x_ff          <= GRID_W'(col);
      // Drop the row when it overflows the grid; the output saturates anyway.
      rem_y_ff          <= row_sat ? '0 : GRID_W'(row_ff);
      jitter_x_ff       <= seq[JIT_W-1:0] ^ scramble.x[JIT_W-1:0];
      jitter_y_ff       <= rev[JIT_W-1:0] ^ delta[JIT_W-1:0];
      z_ff              <= scramble.z ^ z_matrix(seq);
   end

   assign out_status   = status_ff;
   assign out_rem_x    = rem_x_ff;
   assign out_rem_y    = rem_y_ff;
   assign out_jitter_x = jitter_x_ff;
   assign out_jitter_y = jitter_y_ff;
   assign out_z        = z_ff;

endmodule

// ===== design/ssg_frac_div.sv =====
// Three-stage fraction scaler: (cell * 2^16 + jitter) * 2^7 / GRID_SIDE as a 0.23 fraction.
// Depends on ssg_pkg. The cell arrives below GRID_SIDE; the division is a reciprocal multiply.
module ssg_frac_div #(
   parameter int unsigned GRID_SIDE = 128
) (
   input  logic                          clock,
   input  logic [$clog2(GRID_SIDE)-1:0]  in_rem,
   input  logic [ssg_pkg::JIT_W-1:0]     in_jitter,
   output logic [ssg_pkg::FRAC_W-1:0]    out_quot
);
   import ssg_pkg::*;

   // cell * 2^23 = cell * QUOT_HI * GRID_SIDE + cell * REM_HI, so only the small part
   // cell * REM_HI + jitter * 2^7 is left to divide.
   localparam longint unsigned SCALE    = 64'd1 << FRAC_W;
   localparam longint unsigned QUOT_HI  = SCALE / 64'(GRID_SIDE);
   localparam longint unsigned REM_HI   = SCALE % 64'(GRID_SIDE);
   localparam longint unsigned PART_MAX =
      (64'(GRID_SIDE) - 64'd1) * REM_HI + ((64'd1 << JIT_W) - 64'd1) * (64'd1 << FRAC_PAD_W);
   localparam int              PART_W   = $clog2(PART_MAX + 64'd1);
   // Floor reciprocal: the estimate is the true quotient or one short of it.
   localparam longint unsigned RECIP    = (64'd1 << PART_W) / 64'(GRID_SIDE);
   localparam int              RECIP_W  = $clog2(RECIP + 64'd1);
   localparam int              PROD_W   = PART_W + RECIP_W;

   logic [FRAC_W-1:0] base_in, base_ff, base_est_ff;
   logic [PART_W-1:0] part_in, part_ff, part_est_ff;
   logic [PROD_W-1:0] prod;
   logic [FRAC_W-1:0] est_in, est_ff;
   logic [PART_W-1:0] back, resid;
   logic              bump;
   logic [FRAC_W-1:0] quot_in, quot_ff;

   // Split off the exact multiple of the grid side.
   assign base_in = FRAC_W'(in_rem) * FRAC_W'(QUOT_HI);
   assign part_in = PART_W'(in_rem) * PART_W'(REM_HI) + (PART_W'(in_jitter) << FRAC_PAD_W);

   // Estimate the quotient of the small part.
   assign prod   = PROD_W'(part_ff) * PROD_W'(RECIP);
   assign est_in = FRAC_W'(prod >> PART_W);

   // Advance the estimate by one when the remainder still reaches the grid side.
   assign back    = PART_W'(est_ff) * PART_W'(GRID_SIDE);
   assign resid   = part_est_ff - back;
   assign bump    = (resid >= PART_W'(GRID_SIDE));
   assign quot_in = base_est_ff + est_ff + FRAC_W'(bump);

   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      part_ff     <= part_in;
      base_est_ff <= base_ff;
      part_est_ff <= part_ff;
      est_ff      <= est_in;
      quot_ff     <= quot_in;
   end

   assign out_quot = quot_ff;

endmodule

// ===== design/stratified_sobol_sample_generator.sv =====
// Top level of the stratified, scrambled three-dimensional sample generator.
// Depends on ssg_pkg, ssg_map and ssg_frac_div.
//
// Usage:
//  - Command channel: raise start with req_sample_index; the beat is taken at any rising
//    edge where start is high and busy is low. busy is never raised, so a new beat may
//    be issued in every cycle.
//  - Result channel: rsp_strobe is high for exactly one cycle per accepted beat and
//    carries rsp_x_fraction, rsp_y_fraction (0.23) and rsp_z_fraction (0.32). Results
//    come out in issue order. The receiver cannot stall; it must take every beat.
//  - Throughput is one sample per cycle. The accepting edge loads the input register;
//    the reciprocal row split, the matrix stage, the three stages of the fraction
//    scaler and the result register follow.
//  - Configuration: csr_wen writes csr_wdata into scramble x, y or z by csr_index; an
//    index past the list is ignored. Write only while no sample is in flight.
//  - Reset (synchronous, active high): clear the scramble words to zero and flush
//    every sample in flight; no strobe follows a beat taken before reset.
module stratified_sobol_sample_generator #(
   parameter int unsigned GRID_SIDE = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   output logic                            busy,
   input  logic [ssg_pkg::IDX_W-1:0]       req_sample_index,
   output logic                            rsp_strobe,
   output logic [ssg_pkg::FRAC_W-1:0]      rsp_x_fraction,
   output logic [ssg_pkg::FRAC_W-1:0]      rsp_y_fraction,
   output logic [ssg_pkg::WORD_W-1:0]      rsp_z_fraction,
   input  logic                            csr_wen,
   input  logic [ssg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ssg_pkg::WORD_W-1:0]      csr_wdata
);
   import ssg_pkg::*;

   localparam int GRID_W  = $clog2(GRID_SIDE);
   // Sampled edges from the accepting edge to the edge that takes the result beat.
   localparam int LATENCY = DIV_STAGES + 4;

   scramble_type      scramble_ff;
   logic              accept;

   map_status_type    map_status;
   logic [GRID_W-1:0] map_rem_x, map_rem_y;
   logic [JIT_W-1:0]  map_jitter_x, map_jitter_y;
   word_type          map_z;

   logic [FRAC_W-1:0] quot_x, quot_y;

   map_status_type    stat_pipe_ff [DIV_STAGES];
   word_type          z_pipe_ff    [DIV_STAGES];

   logic              rsp_strobe_ff;
   logic [FRAC_W-1:0] rsp_x_ff, rsp_y_ff, rsp_y_in;
   word_type          rsp_z_ff;

   // Every stage advances each cycle, so the command side never has to wait.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // Configuration: clear the scramble words on reset, hold them until rewritten, drop writes past the list.
   always_ff @(posedge clock) begin
      if (reset) begin
         scramble_ff <= '0;
      end else if (csr_wen) begin
         case (csr_index)
            CSR_SCRAMBLE_X: scramble_ff.x <= csr_wdata;
            CSR_SCRAMBLE_Y: scramble_ff.y <= csr_wdata;
            CSR_SCRAMBLE_Z: scramble_ff.z <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Front end: input register, row/column split and the GF(2) matrices.
   ssg_map #(
      .GRID_SIDE   (GRID_SIDE)
   ) u_map (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (accept),
      .in_index    (req_sample_index),
      .scramble    (scramble_ff),
      .out_status  (map_status),
      .out_rem_x   (map_rem_x),
      .out_rem_y   (map_rem_y),
      .out_jitter_x(map_jitter_x),
      .out_jitter_y(map_jitter_y),
      .out_z       (map_z)
   );

   // Fraction dividers: one lane each for x and y, fully pipelined.
   ssg_frac_div #(
      .GRID_SIDE (GRID_SIDE)
   ) u_div_x (
      .clock     (clock),
      .in_rem    (map_rem_x),
      .in_jitter (map_jitter_x),
      .out_quot  (quot_x)
   );

   ssg_frac_div #(
      .GRID_SIDE (GRID_SIDE)
   ) u_div_y (
      .clock     (clock),
      .in_rem    (map_rem_y),
      .in_jitter (map_jitter_y),
      .out_quot  (quot_y)
   );

   // Carry valid, the row overflow flag and z alongside the divider stages.
   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_delay
      if (s == 0) begin : g_head
         always_ff @(posedge clock) begin
            if (reset) begin
               stat_pipe_ff[s].valid <= 1'b0;
            end else begin
               stat_pipe_ff[s].valid <= map_status.valid;
            end
         end
         always_ff @(posedge clock) begin
            stat_pipe_ff[s].row_sat <= map_status.row_sat;
            z_pipe_ff[s]            <= map_z;
         end
      end else begin : g_body
         always_ff @(posedge clock) begin
            if (reset) begin
               stat_pipe_ff[s].valid <= 1'b0;
            end else begin
               stat_pipe_ff[s].valid <= stat_pipe_ff[s-1].valid;
            end
         end
         always_ff @(posedge clock) begin
            stat_pipe_ff[s].row_sat <= stat_pipe_ff[s-1].row_sat;
            z_pipe_ff[s]            <= z_pipe_ff[s-1];
         end
      end
   end

   // Saturate y when the row cell runs past the grid.
   assign rsp_y_in = stat_pipe_ff[DIV_STAGES-1].row_sat ? FRAC_MAX : quot_y;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= stat_pipe_ff[DIV_STAGES-1].valid;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff <= quot_x;
      rsp_y_ff <= rsp_y_in;
      rsp_z_ff <= z_pipe_ff[DIV_STAGES-1];
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_x_fraction = rsp_x_ff;
   assign rsp_y_fraction = rsp_y_ff;
   assign rsp_z_fraction = rsp_z_ff;

`ifndef ASSERT_OFF
   // A result beat only ever follows an accepted command beat at the fixed latency.
   a_strobe_has_cmd: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result strobe without a matching command beat");

   // Every accepted command beat produces its result beat, none lost.
   a_cmd_gets_strobe: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("command beat lost in the pipeline");

   // A row past the grid lands on the saturated y fraction.
   a_row_saturates: assert property (@(posedge clock) disable iff (reset)
      (stat_pipe_ff[DIV_STAGES-1].valid && stat_pipe_ff[DIV_STAGES-1].row_sat)
      |=> (rsp_y_fraction == FRAC_MAX))
      else $error("overflowing row did not saturate y");
`endif

endmodule
